// ===== rtl/core/swg_pkg.sv =====
// ----------------------------------------------------------------------------
// swg_pkg
// Shared types, register codes and constants of the setpoint waveform
// generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swg_pkg;

	localparam int unsigned SINE_TABLE_DEPTH = 1024;
	localparam int unsigned VALUE_WIDTH      = 32;

	localparam int unsigned DATA_W      = 32;
	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned SUM_W       = 34;	// offset +/- amplitude, clamped ramp
	localparam int unsigned ENTRY_W     = 15;	// Q1.15 magnitude

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned SINE_ONE    = 64'd32767;

	typedef enum logic [1:0] {
		MODE_STEP   = 2'd0,
		MODE_RAMP   = 2'd1,
		MODE_SINE   = 2'd2,
		MODE_SQUARE = 2'd3
	} mode_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MODE         = 3'd0,
		REG_AMPLITUDE    = 3'd1,
		REG_OFFSET_LEVEL = 3'd2,
		REG_SLOPE        = 3'd3,
		REG_DELAY        = 3'd4,
		REG_PHASE_INC    = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [DATA_W-1:0] time_ticks;
	} sample_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] setpoint;
		logic                     saturated;
	} result_t;

	typedef struct packed {
		logic [CFG_INDEX_W-1:0] index;
		logic [DATA_W-1:0]      data;
	} cfg_req_t;

	typedef struct packed {
		mode_t                    mode;
		logic signed [DATA_W-1:0] amplitude;
		logic signed [DATA_W-1:0] offset_level;
		logic signed [DATA_W-1:0] slope_per_tick;
		logic [DATA_W-1:0]        delay_ticks;
		logic [DATA_W-1:0]        phase_increment;
	} cfg_t;

endpackage

// ===== rtl/core/swg_stream_if.sv =====
// ----------------------------------------------------------------------------
// swg_stream_if
// Valid/ready channel carrying one request payload per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface swg_stream_if #(
	parameter type payload_t = logic
) ();

	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);

endinterface

// ===== rtl/core/swg_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// swg_cfg_regs
// Configuration register file, written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swg_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	swg_stream_if.sink    cfg,
	output swg_pkg::cfg_t regs
);

	swg_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			case (swg_pkg::reg_index_t'(cfg.payload.index))
				swg_pkg::REG_MODE: begin
					regs_q.mode <= swg_pkg::mode_t'(cfg.payload.data[1:0]);
				end
				swg_pkg::REG_AMPLITUDE: begin
					regs_q.amplitude <= $signed(cfg.payload.data);
				end
				swg_pkg::REG_OFFSET_LEVEL: begin
					regs_q.offset_level <= $signed(cfg.payload.data);
				end
				swg_pkg::REG_SLOPE: begin
					regs_q.slope_per_tick <= $signed(cfg.payload.data);
				end
				swg_pkg::REG_DELAY: begin
					regs_q.delay_ticks <= cfg.payload.data;
				end
				swg_pkg::REG_PHASE_INC: begin
					regs_q.phase_increment <= cfg.payload.data;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/swg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// swg_sine_rom
// Quarter-wave sine ROM, Q1.15 magnitude, registered read. Entry m holds
// sin(pi/2 * 4m / DEPTH); contents are computed at elaboration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swg_sine_rom #(
	parameter int unsigned DEPTH = swg_pkg::SINE_TABLE_DEPTH
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [$clog2(DEPTH)-2:0]          addr,
	output logic [swg_pkg::ENTRY_W-1:0]       data
);

	localparam int unsigned QN = DEPTH / 4;
	localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

	// Q2.30 Taylor series to the x^15 term, each term truncated
	function automatic logic [swg_pkg::ENTRY_W-1:0] quarter_sine(input longint unsigned u);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned vq;
		longint          acc;
		x    = (u * swg_pkg::HALF_PI_Q30 + DEPTH / 2) / DEPTH;
		x2   = (x * x) >> 30;
		term = x;
		acc  = longint'(x);
		for (int n = 1; n <= 7; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if ((n & 1) == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		if (acc < 0)
			acc = 0;
		vq = (unsigned'(acc) * swg_pkg::SINE_ONE + (64'd1 << 29)) >> 30;
		if (vq > swg_pkg::SINE_ONE)
			vq = swg_pkg::SINE_ONE;
		return swg_pkg::ENTRY_W'(vq);
	endfunction

	logic [swg_pkg::ENTRY_W-1:0] sin_tab [QN+1];
	logic [swg_pkg::ENTRY_W-1:0] data_q;

	for (genvar g = 0; g <= QN; g++) begin : g_tab
		localparam logic [swg_pkg::ENTRY_W-1:0] ENTRY = quarter_sine(64'(4 * g));
		assign sin_tab[g] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_q <= sin_tab[addr];
	end

	assign data = data_q;

endmodule

// ===== rtl/core/swg_pipe.sv =====
// ----------------------------------------------------------------------------
// swg_pipe
// Five-stage setpoint datapath: delay subtract, phase/ramp multiply,
// ROM read and ramp sum, amplitude multiply and clamp, final sum and clip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swg_pipe #(
	parameter int unsigned SINE_TABLE_DEPTH = swg_pkg::SINE_TABLE_DEPTH,
	parameter int unsigned VALUE_WIDTH      = swg_pkg::VALUE_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  swg_pkg::cfg_t regs,
	swg_stream_if.sink    sample,
	swg_stream_if.source  result
);

	localparam int unsigned DW    = swg_pkg::DATA_W;
	localparam int unsigned SW    = swg_pkg::SUM_W;
	localparam int unsigned EW    = swg_pkg::ENTRY_W;
	localparam int unsigned L     = $clog2(SINE_TABLE_DEPTH);
	localparam int unsigned IW    = L - 1;
	localparam int unsigned QN    = SINE_TABLE_DEPTH / 4;
	localparam int unsigned EXT_W = (VALUE_WIDTH > SW) ? VALUE_WIDTH : SW;
	localparam logic signed [EXT_W-1:0] SAT_HI =
		EXT_W'((64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1);
	localparam logic signed [EXT_W-1:0] SAT_LO = ~SAT_HI;

	// handshake / stage enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5 = !v_s5 || result.ready;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;

	assign sample.ready = en_s1;
	assign result.valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= sample.valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: elapsed time since delay
	logic [DW:0]   diff_c;
	logic [DW-1:0] time_s1;
	logic [DW-1:0] dt_s1;
	logic          before_s1;

	assign diff_c = {1'b0, sample.payload.time_ticks} - {1'b0, regs.delay_ticks};

	always_ff @(posedge clk) begin
		if (en_s1) begin
			time_s1   <= sample.payload.time_ticks;
			dt_s1     <= diff_c[DW-1:0];
			before_s1 <= diff_c[DW];
		end
	end

	// stage 2: phase and ramp products
	logic [DW-1:0]            mul_src_c;
	logic [DW-1:0]            phase_c;
	logic signed [2*DW:0]     ramp_prod_c;
	logic [DW-1:0]            phase_s2;
	logic signed [2*DW-1:0]   ramp_prod_s2;
	logic                     before_s2;

	assign mul_src_c   = (regs.mode == swg_pkg::MODE_SQUARE) ? time_s1 : dt_s1;
	assign phase_c     = regs.phase_increment * mul_src_c;
	assign ramp_prod_c = regs.slope_per_tick * $signed({1'b0, dt_s1});

	always_ff @(posedge clk) begin
		if (en_s2) begin
			phase_s2     <= phase_c;
			ramp_prod_s2 <= ramp_prod_c[2*DW-1:0];
			before_s2    <= before_s1;
		end
	end

	// stage 3: ROM read, ramp sum, square half
	logic [L-3:0]           quad_pos_c;
	logic [IW-1:0]          rom_idx_c;
	logic [EW-1:0]          entry_s3;
	logic                   neg_s3;
	logic                   sq_pos_s3;
	logic signed [2*DW-1:0] ramp_v_s3;
	logic                   before_s3;

	assign quad_pos_c = phase_s2[DW-3 -: (L-2)];
	assign rom_idx_c  = phase_s2[DW-2] ? (IW'(QN) - {1'b0, quad_pos_c}) : {1'b0, quad_pos_c};

	swg_sine_rom #(
		.DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.en   (en_s3),
		.addr (rom_idx_c),
		.data (entry_s3)
	);

	always_ff @(posedge clk) begin
		if (en_s3) begin
			neg_s3    <= phase_s2[DW-1];
			sq_pos_s3 <= (phase_s2 != '0) && !phase_s2[DW-1];
			ramp_v_s3 <= (2*DW)'(regs.offset_level) + ramp_prod_s2;
			before_s3 <= before_s2;
		end
	end

	// stage 4: sine product, clamp and select of the other modes
	logic signed [EW:0]       sentry_c;
	logic signed [DW+EW:0]    sine_prod_c;
	logic signed [SW-1:0]     offset_c;
	logic signed [SW-1:0]     target_c;
	logic signed [SW-1:0]     low_c;
	logic signed [2*DW-1:0]   target_wide_c;
	logic signed [SW-1:0]     ramp_sel_c;
	logic signed [SW-1:0]     nv_c;
	logic                     is_sine_c;
	logic signed [DW+EW:0]    sine_prod_s4;
	logic signed [SW-1:0]     nv_s4;
	logic                     is_sine_s4;

	assign sentry_c      = neg_s3 ? -$signed({1'b0, entry_s3}) : $signed({1'b0, entry_s3});
	assign sine_prod_c   = regs.amplitude * sentry_c;
	assign offset_c      = SW'(regs.offset_level);
	assign target_c      = offset_c + SW'(regs.amplitude);
	assign low_c         = offset_c - SW'(regs.amplitude);
	assign target_wide_c = (2*DW)'(target_c);
	assign is_sine_c     = (regs.mode == swg_pkg::MODE_SINE) && !before_s3;

	always_comb begin
		if (regs.slope_per_tick > 32'sd0)
			ramp_sel_c = (ramp_v_s3 > target_wide_c) ? target_c : ramp_v_s3[SW-1:0];
		else
			ramp_sel_c = (ramp_v_s3 < target_wide_c) ? target_c : ramp_v_s3[SW-1:0];
	end

	always_comb begin
		if (regs.mode == swg_pkg::MODE_SQUARE) begin
			nv_c = sq_pos_s3 ? target_c : low_c;
		end else if (before_s3) begin
			nv_c = offset_c;
		end else begin
			case (regs.mode)
				swg_pkg::MODE_STEP: nv_c = target_c;
				swg_pkg::MODE_RAMP: nv_c = ramp_sel_c;
				default:            nv_c = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			sine_prod_s4 <= sine_prod_c;
			nv_s4        <= nv_c;
			is_sine_s4   <= is_sine_c;
		end
	end

	// stage 5: sine rounding and sum, clip to the value range
	logic signed [DW+EW:0]    round_c;
	logic signed [SW-1:0]     sine_sum_c;
	logic signed [EXT_W-1:0]  v_ext_c;
	logic signed [EXT_W-1:0]  clip_c;
	logic                     sat_c;
	logic [DW-1:0]            setpoint_s5;
	logic                     sat_s5;

	assign round_c    = sine_prod_s4 + (DW+EW+1)'(16384);
	assign sine_sum_c = SW'(regs.offset_level) + SW'($signed(round_c[DW+EW:EW]));
	assign v_ext_c    = EXT_W'(is_sine_s4 ? sine_sum_c : nv_s4);

	always_comb begin
		if (v_ext_c > SAT_HI) begin
			clip_c = SAT_HI;
			sat_c  = 1'b1;
		end else if (v_ext_c < SAT_LO) begin
			clip_c = SAT_LO;
			sat_c  = 1'b1;
		end else begin
			clip_c = v_ext_c;
			sat_c  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			setpoint_s5 <= clip_c[DW-1:0];
			sat_s5      <= sat_c;
		end
	end

	assign result.payload.setpoint  = $signed(setpoint_s5);
	assign result.payload.saturated = sat_s5;

	// checks
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.payload.saturated |->
			(result.payload.setpoint == SAT_HI[DW-1:0] ||
			 result.payload.setpoint == SAT_LO[DW-1:0]))
		else $error("saturated result not at a clip bound");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && !result.ready |-> !sample.ready)
		else $error("request taken into a full, stalled pipeline");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !en_s4 |=> $stable(nv_s4) && $stable(is_sine_s4) && $stable(sine_prod_s4))
		else $error("stage 4 changed while stalled");

	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !en_s5 |=> v_s5 && $stable(setpoint_s5) && $stable(sat_s5))
		else $error("output stage changed while stalled");

endmodule

// ===== rtl/core/setpoint_waveform_generator_top.sv =====
// ----------------------------------------------------------------------------
// setpoint_waveform_generator_top
// Takes one time value per request and returns one signed Q16.16 setpoint
// (step, ramp, sine or square) with a clip flag. The datapath is a
// five-stage pipeline: one request is taken every clock cycle while the
// output side does not stall, and its result is registered in each stage
// in turn; the registered sine ROM lies between the two multiplier stages.
// A stalled output holds its result while empty stages keep filling.
// Registers are written through the configuration channel, which is always
// ready; write them only while no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module setpoint_waveform_generator_top #(
	parameter int unsigned SINE_TABLE_DEPTH = swg_pkg::SINE_TABLE_DEPTH,
	parameter int unsigned VALUE_WIDTH      = swg_pkg::VALUE_WIDTH
) (
	input  logic         clk,
	input  logic         arst_n,
	swg_stream_if.sink   cfg,
	swg_stream_if.sink   sample,
	swg_stream_if.source result
);

	swg_pkg::cfg_t regs;

	swg_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	swg_pipe #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.VALUE_WIDTH      (VALUE_WIDTH)
	) u_pipe (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.sample (sample),
		.result (result)
	);

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the setpoint waveform generator. Each accepted
// time request is run through a local model of the step, ramp, sine and
// square modes with saturation. The expected setpoints are queued in order
// and compared with every result the block returns. Random gaps on both
// channels and one long output stall exercise the pipeline back pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	import swg_pkg::*;

	localparam int unsigned WATCHDOG_LIMIT = 4000;
	localparam int unsigned HOLD_CYCLES    = 300;
	localparam longint      Q_MAX          = 64'sd2147483647;
	localparam longint      Q_MIN          = -64'sd2147483648;

	class setpoint_tracker;
		mode_t       mode;
		longint      amplitude;
		longint      offset_level;
		longint      slope;
		logic [31:0] delay;
		logic [31:0] phase_inc;
		int          sine_rom[SINE_TABLE_DEPTH];
		result_t     pending_setpoints[$];
		int unsigned faults;
		int unsigned checked;
		int unsigned clipped;

		function new();
			mode         = MODE_STEP;
			amplitude    = 0;
			offset_level = 0;
			slope        = 0;
			delay        = '0;
			phase_inc    = '0;
			faults       = 0;
			checked      = 0;
			clipped      = 0;
			for (int k = 0; k < SINE_TABLE_DEPTH; k++) sine_rom[k] = rom_entry(k);
		endfunction

		// sin(pi/2 * u / depth) in Q1.15, Taylor series in Q2.30
		function longint quarter_wave(longint unsigned u);
			longint unsigned x;
			longint unsigned x2;
			longint unsigned term;
			longint          acc;
			longint          v;
			x    = (u * HALF_PI_Q30 + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) acc = acc - longint'(term);
				else acc = acc + longint'(term);
			end
			if (acc < 0) acc = 0;
			v = longint'((longint'(unsigned'(acc)) * SINE_ONE + (64'd1 << 29)) >> 30);
			if (v > longint'(SINE_ONE)) v = longint'(SINE_ONE);
			return v;
		endfunction

		function int rom_entry(int k);
			longint unsigned k4;
			longint unsigned q;
			longint unsigned r;
			longint          s;
			k4 = 4 * k;
			q  = k4 / SINE_TABLE_DEPTH;
			r  = k4 % SINE_TABLE_DEPTH;
			s  = quarter_wave(q[0] ? SINE_TABLE_DEPTH - r : r);
			return (q >= 2) ? int'(-s) : int'(s);
		endfunction

		function void write_reg(reg_index_t idx, logic [31:0] d);
			case (idx)
				REG_MODE:         mode = mode_t'(d[1:0]);
				REG_AMPLITUDE:    amplitude = longint'($signed(d));
				REG_OFFSET_LEVEL: offset_level = longint'($signed(d));
				REG_SLOPE:        slope = longint'($signed(d));
				REG_DELAY:        delay = d;
				REG_PHASE_INC:    phase_inc = d;
				default: ;
			endcase
		endfunction

		function result_t predict_setpoint(logic [31:0] t);
			logic [31:0]     dt;
			logic [31:0]     ph;
			longint unsigned idx;
			longint          target;
			longint          v;
			result_t         r;
			dt     = t - delay;
			target = offset_level + amplitude;
			if (mode == MODE_SQUARE) begin
				ph = phase_inc * t;
				v  = (ph != 0 && ph < 32'h8000_0000) ? target : offset_level - amplitude;
			end else if (t < delay) begin
				v = offset_level;
			end else begin
				case (mode)
					MODE_STEP: v = target;
					MODE_RAMP: begin
						v = offset_level + slope * longint'({32'd0, dt});
						if (slope > 0) begin
							if (v > target) v = target;
						end else begin
							if (v < target) v = target;
						end
					end
					default: begin
						ph  = phase_inc * dt;
						idx = (longint'(unsigned'({32'd0, ph})) * SINE_TABLE_DEPTH) >> 32;
						v   = offset_level
						      + ((amplitude * longint'(sine_rom[idx]) + 64'sd16384) >>> 15);
					end
				endcase
			end
			r.saturated = 1'b0;
			if (v > Q_MAX) begin
				v = Q_MAX;
				r.saturated = 1'b1;
			end
			if (v < Q_MIN) begin
				v = Q_MIN;
				r.saturated = 1'b1;
			end
			r.setpoint = v[31:0];
			return r;
		endfunction

		function void note_time(logic [31:0] t);
			pending_setpoints.push_back(predict_setpoint(t));
		endfunction

		function void check_setpoint(result_t got);
			result_t want;
			if (pending_setpoints.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("[%0t] unexpected result: setpoint %h sat %b",
					         $time, got.setpoint, got.saturated);
				return;
			end
			want = pending_setpoints.pop_front();
			checked++;
			if (want.saturated) clipped++;
			if (got.setpoint !== want.setpoint || got.saturated !== want.saturated) begin
				faults++;
				if (faults <= 10)
					$display("[%0t] result %0d mismatch: expected setpoint %h sat %b, got %h sat %b",
					         $time, checked, want.setpoint, want.saturated,
					         got.setpoint, got.saturated);
			end
		endfunction

		function int queued();
			return pending_setpoints.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	swg_stream_if #(.payload_t(cfg_req_t)) cfg_if ();
	swg_stream_if #(.payload_t(sample_t))  sample_if ();
	swg_stream_if #(.payload_t(result_t))  result_if ();

	setpoint_waveform_generator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.sample (sample_if),
		.result (result_if)
	);

	setpoint_tracker tracker = new();

	bit          gaps_on;
	bit          hold_req;
	int unsigned hold_left;
	int unsigned idle_cycles;
	int unsigned requests_sent;
	int unsigned phases_run;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		arst_n            = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.payload    = '0;
		sample_if.valid   = 1'b0;
		sample_if.payload = '0;
		result_if.ready   = 1'b0;
	end

	// output side: random stalls plus one long hold-off on request
	initial begin
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_if.ready = 1'b0;
			end else begin
				result_if.ready = !(gaps_on && $urandom_range(0, 99) < 19);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			tracker.check_setpoint(result_if.payload);
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
		             || (cfg_if.valid && cfg_if.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// called and returns at a falling edge
	task automatic drive_sample(logic [31:0] t);
		while (gaps_on && $urandom_range(0, 99) < 19) begin
			sample_if.valid = 1'b0;
			@(negedge clk);
		end
		sample_if.valid              = 1'b1;
		sample_if.payload.time_ticks = t;
		@(posedge clk);
		while (!sample_if.ready) @(posedge clk);
		tracker.note_time(t);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [31:0] d);
		cfg_if.valid         = 1'b1;
		cfg_if.payload.index = idx;
		cfg_if.payload.data  = d;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
		tracker.write_reg(idx, d);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic drain();
		sample_if.valid = 1'b0;
		while (tracker.queued() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_config(mode_t m, logic [31:0] amp, logic [31:0] off,
	                          logic [31:0] slp, logic [31:0] dly, logic [31:0] inc);
		drain();
		write_reg(REG_MODE, {30'd0, m});
		write_reg(REG_AMPLITUDE, amp);
		write_reg(REG_OFFSET_LEVEL, off);
		write_reg(REG_SLOPE, slp);
		write_reg(REG_DELAY, dly);
		write_reg(REG_PHASE_INC, inc);
		phases_run++;
	endtask

	task automatic drive_list(logic [31:0] times[$]);
		foreach (times[i]) drive_sample(times[i]);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			4: return 32'h0000_0001;
			5, 6: return 32'($urandom_range(0, 2 * 1048576)) - 32'd1048576;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_slope();
		if ($urandom_range(0, 1)) return 32'($urandom_range(0, 131072)) - 32'd65536;
		return pick_value();
	endfunction

	function automatic logic [31:0] pick_delay();
		case ($urandom_range(0, 9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2, 3, 4, 5: return $urandom_range(0, 5000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] next_time(logic [31:0] dly);
		case ($urandom_range(0, 9))
			0: return dly + $urandom_range(0, 8) - 32'd4;
			1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			2, 3, 4: return dly + $urandom_range(0, 4096);
			5: return dly - $urandom_range(1, 4096);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		mode_t       m;
		logic [31:0] dly;
		requests_sent = 0;
		phases_run    = 0;
		gaps_on       = 1'b1;
		hold_req      = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// step edges around the delay
		set_config(MODE_STEP, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'd1000, 32'h0);
		drive_list('{32'd0, 32'd999, 32'd1000, 32'd1001, 32'hFFFF_FFFF});
		// step clipping high
		set_config(MODE_STEP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'd0, 32'h0);
		drive_list('{32'd0, 32'hFFFF_FFFF});
		// ramp up to the clamp
		set_config(MODE_RAMP, 32'h0010_0000, 32'h0, 32'h0000_8000, 32'd100, 32'h0);
		drive_list('{32'd99, 32'd100, 32'd101, 32'd132, 32'd133, 32'hFFFF_FFFF});
		// steepest falling ramp, clipping low
		set_config(MODE_RAMP, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'h0);
		drive_list('{32'd0, 32'd1, 32'hFFFF_FFFF});
		// sine at quarter points
		set_config(MODE_SINE, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'd5, 32'h4000_0000);
		drive_list('{32'd4, 32'd5, 32'd6, 32'd7, 32'd8});
		// square at phase zero, quarter, half and three quarters
		set_config(MODE_SQUARE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'd3, 32'h4000_0000);
		drive_list('{32'd0, 32'd1, 32'd2, 32'd3});

		for (int ph = 0; ph < 29; ph++) begin
			gaps_on = !(ph >= 8 && ph <= 13);
			m       = (ph < 8) ? mode_t'(ph % 4) : mode_t'($urandom_range(0, 3));
			dly     = pick_delay();
			set_config(m, pick_value(), pick_value(), pick_slope(), dly, pick_value());
			if (ph == 16) hold_req = 1'b1;
			repeat (50) drive_sample(next_time(dly));
		end

		drain();
		repeat (20) @(posedge clk);
		if (tracker.queued() != 0) tracker.faults += tracker.queued();

		$display("Covered %0d time requests over %0d register settings in all four modes;",
		         requests_sent, phases_run);
		$display("%0d results checked, %0d expected clipped, %0d failures.",
		         tracker.checked, tracker.clipped, tracker.faults);
		if (tracker.faults == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
